// ===== rtl/pli_pkg.sv =====
// Shared constants, codes and command/status types for the posting list intersect block.
`default_nettype none
package pli_pkg;

  localparam int MAX_TERMS_DEF  = 4;
  localparam int LIST_DEPTH_DEF = 64;
  localparam int DOC_BITS_DEF   = 24;

  localparam int DOC_PORT_W = 24;
  localparam int WEIGHT_W   = 16;
  localparam int NUM_WOUT   = 4;
  localparam int TC_W       = 3;
  localparam int N_W        = 4;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic init;
    logic empty;
    logic step;
    logic finish;
  } pli_cmd_t;

  typedef struct packed {
    logic any_empty;
    logic exhausted;
  } pli_stat_t;

endpackage
`default_nettype wire

// ===== rtl/pli_ctrl.sv =====
// Controller state machine: decodes items and sequences the list walk.
`default_nettype none
module pli_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       kind,
  input  pli_pkg::pli_stat_t stat,
  output logic             busy,
  output pli_pkg::pli_cmd_t  cmd
);
  import pli_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_LOAD:  cmd.load  = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_RUN: begin
              if (stat.any_empty) begin
                cmd.empty = 1'b1;
              end else begin
                cmd.init   = 1'b1;
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // heads are being read this cycle; stop once any active list runs out
        if (stat.exhausted) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pli_dp.sv =====
// Datapath: per-list entry memories, heads, compare/min logic and result registers.
`default_nettype none
module pli_dp #(
  parameter int MAX_TERMS  = pli_pkg::MAX_TERMS_DEF,
  parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEF,
  parameter int DOC_BITS   = pli_pkg::DOC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pli_pkg::pli_cmd_t                  cmd,
  input  logic [1:0]                         term,
  input  logic [pli_pkg::DOC_PORT_W-1:0]     doc_id,
  input  logic [pli_pkg::WEIGHT_W-1:0]       weight,
  input  logic                               cfg_valid,
  input  logic [pli_pkg::TC_W-1:0]           cfg_data,
  output pli_pkg::pli_stat_t                 stat,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [pli_pkg::DOC_PORT_W-1:0]     match_doc,
  output logic [pli_pkg::WEIGHT_W-1:0]       weight_a,
  output logic [pli_pkg::WEIGHT_W-1:0]       weight_b,
  output logic [pli_pkg::WEIGHT_W-1:0]       weight_c,
  output logic [pli_pkg::WEIGHT_W-1:0]       weight_d,
  output logic                               last
);
  import pli_pkg::*;

  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int HW  = $clog2(LIST_DEPTH + 1);
  localparam int TIW = $clog2(MAX_TERMS);
  localparam int EW  = DOC_BITS + WEIGHT_W;

  logic [TC_W-1:0]     tc;
  logic [N_W-1:0]      n;
  logic [MAX_TERMS-1:0] act;
  logic [MAX_TERMS-1:0] wr;
  logic [HW-1:0]       len      [MAX_TERMS];
  logic [HW-1:0]       head     [MAX_TERMS];
  logic [DOC_BITS-1:0] last_doc [MAX_TERMS];
  logic [EW-1:0]       rd_q     [MAX_TERMS];
  logic [DOC_BITS-1:0] rd_doc   [MAX_TERMS];
  logic [WEIGHT_W-1:0] rd_w     [MAX_TERMS];
  logic [WEIGHT_W-1:0] cur_w    [NUM_WOUT];
  logic [DOC_BITS-1:0] in_doc;
  logic [DOC_BITS-1:0] min_doc;
  logic [TIW-1:0]      min_t;
  logic                same;
  logic                exhausted;
  logic                any_empty;

  logic                pend_valid;
  logic [DOC_BITS-1:0] pend_doc;
  logic [WEIGHT_W-1:0] pend_w [NUM_WOUT];
  logic [WEIGHT_W-1:0] o_w    [NUM_WOUT];
  logic                emit_match;

  assign in_doc = DOC_BITS'(doc_id);

  // term count register; zero means one, above the list count means all lists
  always_ff @(posedge clk) begin
    if (rst) begin
      tc <= TC_W'(1);
    end else if (cfg_valid) begin
      tc <= cfg_data;
    end
  end

  always_comb begin
    if (tc == '0) begin
      n = N_W'(1);
    end else if (N_W'(tc) > N_W'(MAX_TERMS)) begin
      n = N_W'(MAX_TERMS);
    end else begin
      n = N_W'(tc);
    end
  end

  for (genvar t = 0; t < MAX_TERMS; t++) begin : g_list
    logic [EW-1:0] mem [LIST_DEPTH];

    assign act[t] = (N_W'(t) < n);
    // drop appends to a full list or ones that break the ascending order
    assign wr[t]  = cmd.load && (int'(term) == t) && (len[t] < HW'(LIST_DEPTH)) &&
                    ((len[t] == '0) || (in_doc > last_doc[t]));

    always_ff @(posedge clk) begin
      if (wr[t]) begin
        mem[len[t][AW-1:0]] <= {in_doc, weight};
      end
      rd_q[t] <= mem[head[t][AW-1:0]];
    end

    always_ff @(posedge clk) begin
      if (wr[t]) begin
        last_doc[t] <= in_doc;
      end
    end

    assign rd_doc[t] = rd_q[t][EW-1:WEIGHT_W];
    assign rd_w[t]   = rd_q[t][WEIGHT_W-1:0];
  end

  for (genvar j = 0; j < NUM_WOUT; j++) begin : g_wsel
    if (j < MAX_TERMS) begin : g_on
      assign cur_w[j] = act[j] ? rd_w[j] : '0;
    end else begin : g_off
      assign cur_w[j] = '0;
    end
  end

  always_comb begin
    exhausted = 1'b0;
    any_empty = 1'b0;
    same      = 1'b1;
    min_t     = '0;
    min_doc   = rd_doc[0];
    for (int t = 0; t < MAX_TERMS; t++) begin
      if (act[t]) begin
        if (head[t] >= len[t]) exhausted = 1'b1;
        if (len[t] == '0) any_empty = 1'b1;
      end
    end
    // strict compare keeps the lowest numbered list on equal ids
    for (int t = 1; t < MAX_TERMS; t++) begin
      if (act[t]) begin
        if (rd_doc[t] != rd_doc[0]) same = 1'b0;
        if (rd_doc[t] < min_doc) begin
          min_doc = rd_doc[t];
          min_t   = TIW'(t);
        end
      end
    end
  end

  assign stat.any_empty = any_empty;
  assign stat.exhausted = exhausted;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_TERMS; t++) begin
        len[t]  <= '0;
        head[t] <= '0;
      end
    end else begin
      for (int t = 0; t < MAX_TERMS; t++) begin
        if (cmd.clear) begin
          len[t] <= '0;
        end else if (wr[t]) begin
          len[t] <= len[t] + 1'b1;
        end
        if (cmd.init) begin
          head[t] <= '0;
        end else if (cmd.step && (same ? act[t] : (TIW'(t) == min_t))) begin
          head[t] <= head[t] + 1'b1;
        end
      end
    end
  end

  // hold the newest match back until it is known whether it ends the run
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.init) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && same) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && same) begin
      pend_doc <= rd_doc[0];
      for (int j = 0; j < NUM_WOUT; j++) begin
        pend_w[j] <= cur_w[j];
      end
    end
  end

  assign emit_match = cmd.step && same && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.empty || cmd.finish || emit_match;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.empty || (cmd.finish && !pend_valid)) begin
      status    <= cmd.empty ? ST_EMPTY : ST_NONE;
      match_doc <= '0;
      for (int j = 0; j < NUM_WOUT; j++) begin
        o_w[j] <= '0;
      end
      last <= 1'b1;
    end else if (cmd.finish || emit_match) begin
      status    <= ST_MATCH;
      match_doc <= DOC_PORT_W'(pend_doc);
      for (int j = 0; j < NUM_WOUT; j++) begin
        o_w[j] <= pend_w[j];
      end
      last <= cmd.finish;
    end
  end

  assign weight_a = o_w[0];
  assign weight_b = o_w[1];
  assign weight_c = o_w[2];
  assign weight_d = o_w[3];

endmodule
`default_nettype wire

// ===== rtl/posting_list_intersect.sv =====
// Posting list intersect top level: start/busy item port, term count write port, result strobe.
// Append, clear and an unused kind leave busy low, so loads go one a cycle.
// A run holds busy through its walk steps (at most the sum of active list lengths): an entry read
// state and a compare state per step, then a read state that finds a list out.
// A match strobes in the cycle after the step that settles it, the last one as busy falls; an empty
// list strobes status in the cycle after start, no busy. Reset: lists empty, term count 1; no stall.
`default_nettype none
module posting_list_intersect #(
  parameter int MAX_TERMS  = pli_pkg::MAX_TERMS_DEF,
  parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEF,
  parameter int DOC_BITS   = pli_pkg::DOC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind,
  input  logic [1:0]                     term,
  input  logic [pli_pkg::DOC_PORT_W-1:0] doc_id,
  input  logic [pli_pkg::WEIGHT_W-1:0]   weight,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pli_pkg::TC_W-1:0]       cfg_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [pli_pkg::DOC_PORT_W-1:0] match_doc,
  output logic [pli_pkg::WEIGHT_W-1:0]   weight_a,
  output logic [pli_pkg::WEIGHT_W-1:0]   weight_b,
  output logic [pli_pkg::WEIGHT_W-1:0]   weight_c,
  output logic [pli_pkg::WEIGHT_W-1:0]   weight_d,
  output logic                           last
);
  import pli_pkg::*;

  pli_cmd_t  cmd;
  pli_stat_t stat;

  // the term count register takes a beat in any cycle
  assign cfg_ready = 1'b1;

  pli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pli_dp #(
    .MAX_TERMS  (MAX_TERMS),
    .LIST_DEPTH (LIST_DEPTH),
    .DOC_BITS   (DOC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .term      (term),
    .doc_id    (doc_id),
    .weight    (weight),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .match_doc (match_doc),
    .weight_a  (weight_a),
    .weight_b  (weight_b),
    .weight_c  (weight_c),
    .weight_d  (weight_d),
    .last      (last)
  );

endmodule
`default_nettype wire

// ===== tb/posting_list_intersect_tb.sv =====
// Self-checking testbench for posting_list_intersect: directed cases, then random load/run phases.
`default_nettype none
module posting_list_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int TERMS = MAX_TERMS_DEF;
  localparam int EXP_DEPTH = 1024;

  typedef struct packed {
    logic [1:0]            status;
    logic [DOC_PORT_W-1:0] doc;
    logic [WEIGHT_W-1:0]   wa;
    logic [WEIGHT_W-1:0]   wb;
    logic [WEIGHT_W-1:0]   wc;
    logic [WEIGHT_W-1:0]   wd;
    logic                  last;
  } hit_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            kind;
  logic [1:0]            term;
  logic [DOC_PORT_W-1:0] doc_id;
  logic [WEIGHT_W-1:0]   weight;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TC_W-1:0]       cfg_data;
  logic                  done;
  logic [1:0]            status;
  logic [DOC_PORT_W-1:0] match_doc;
  logic [WEIGHT_W-1:0]   weight_a;
  logic [WEIGHT_W-1:0]   weight_b;
  logic [WEIGHT_W-1:0]   weight_c;
  logic [WEIGHT_W-1:0]   weight_d;
  logic                  last;

  // mirror of the block's lists and term count
  logic [DOC_PORT_W-1:0] list_doc [TERMS][DEPTH];
  logic [WEIGHT_W-1:0]   list_wt  [TERMS][DEPTH];
  int                    list_len [TERMS];
  logic [TC_W-1:0]       term_cfg;

  // expected hits, oldest at exp_rd
  hit_t exp_mem [EXP_DEPTH];
  int   exp_wr;
  int   exp_rd;
  hit_t want_hit;

  int errors;
  int items_sent;
  int items_applied;
  int runs_sent;
  int hits_checked;
  int cfg_writes;
  bit no_idle;

  posting_list_intersect uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .term      (term),
    .doc_id    (doc_id),
    .weight    (weight),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .match_doc (match_doc),
    .weight_a  (weight_a),
    .weight_b  (weight_b),
    .weight_c  (weight_c),
    .weight_d  (weight_d),
    .last      (last)
  );

  always #2 clk = ~clk;

  function automatic int hits_waiting();
    return exp_wr - exp_rd;
  endfunction

  function automatic void queue_hit(input hit_t h);
    exp_mem[exp_wr % EXP_DEPTH] = h;
    exp_wr++;
  endfunction

  function automatic hit_t status_hit(input logic [1:0] st);
    hit_t h;
    h = '0;
    h.status = st;
    h.last = 1'b1;
    return h;
  endfunction

  // walk the active lists and queue every hit that the run produces
  function automatic void walk_lists();
    int n;
    int t;
    int min_t;
    int heads [TERMS];
    logic [DOC_PORT_W-1:0] first;
    logic [DOC_PORT_W-1:0] min_d;
    logic [DOC_PORT_W-1:0] d;
    logic [WEIGHT_W-1:0] w [TERMS];
    bit same;
    bit running;
    bit have_pend;
    bit empty_seen;
    hit_t pend;
    hit_t cur;
    n = (term_cfg == 0) ? 1 : ((term_cfg > TERMS) ? TERMS : int'(term_cfg));
    empty_seen = 1'b0;
    for (t = 0; t < n; t++) begin
      if (list_len[t] == 0) empty_seen = 1'b1;
    end
    if (empty_seen) begin
      queue_hit(status_hit(ST_EMPTY));
      return;
    end
    for (t = 0; t < TERMS; t++) heads[t] = 0;
    have_pend = 1'b0;
    pend = '0;
    running = 1'b1;
    while (running) begin
      for (t = 0; t < n; t++) begin
        if (heads[t] >= list_len[t]) running = 1'b0;
      end
      if (running) begin
        first = list_doc[0][heads[0]];
        min_d = first;
        min_t = 0;
        same = 1'b1;
        for (t = 1; t < n; t++) begin
          d = list_doc[t][heads[t]];
          if (d != first) same = 1'b0;
          // strict compare keeps the lowest numbered list on a tie
          if (d < min_d) begin
            min_d = d;
            min_t = t;
          end
        end
        if (same) begin
          for (t = 0; t < TERMS; t++) w[t] = (t < n) ? list_wt[t][heads[t]] : '0;
          cur = '0;
          cur.status = ST_MATCH;
          cur.doc = first;
          cur.wa = w[0];
          cur.wb = w[1];
          cur.wc = w[2];
          cur.wd = w[3];
          for (t = 0; t < n; t++) heads[t]++;
          if (have_pend) queue_hit(pend);
          pend = cur;
          have_pend = 1'b1;
        end else begin
          heads[min_t]++;
        end
      end
    end
    if (have_pend) begin
      pend.last = 1'b1;
      queue_hit(pend);
    end else begin
      queue_hit(status_hit(ST_NONE));
    end
  endfunction

  // update the mirror for one accepted item; returns 1 if the item had any effect
  function automatic bit apply_item(input logic [1:0] k, input logic [1:0] tm,
                                    input logic [DOC_PORT_W-1:0] dc,
                                    input logic [WEIGHT_W-1:0] wt);
    int t;
    int len;
    bit took;
    took = 1'b0;
    case (k)
      KIND_LOAD: begin
        len = list_len[tm];
        if (len < DEPTH && (len == 0 || dc > list_doc[tm][len-1])) begin
          list_doc[tm][len] = dc;
          list_wt[tm][len] = wt;
          list_len[tm] = len + 1;
          took = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (t = 0; t < TERMS; t++) list_len[t] = 0;
        took = 1'b1;
      end
      KIND_RUN: begin
        walk_lists();
        took = 1'b1;
      end
      default: took = 1'b0;
    endcase
    return took;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [1:0] tm,
                           input logic [DOC_PORT_W-1:0] dc, input logic [WEIGHT_W-1:0] wt);
    int gap;
    start <= 1'b1;
    kind <= k;
    term <= tm;
    doc_id <= dc;
    weight <= wt;
    do @(posedge clk); while (busy);
    if (apply_item(k, tm, dc, wt)) items_applied++;
    items_sent++;
    if (k == KIND_RUN) runs_sent++;
    gap = pick_gap();
    // hold start high when the next beat follows at once
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load(input logic [1:0] tm, input logic [DOC_PORT_W-1:0] dc,
                      input logic [WEIGHT_W-1:0] wt);
    send_item(KIND_LOAD, tm, dc, wt);
  endtask

  task automatic run_lists();
    send_item(KIND_RUN, 2'($urandom), 24'($urandom), 16'($urandom));
  endtask

  task automatic clear_lists();
    send_item(KIND_CLEAR, 2'($urandom), 24'($urandom), 16'($urandom));
  endtask

  // idle the sender until every expected hit has arrived and the block settles
  task automatic drain();
    start <= 1'b0;
    while (hits_waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [TC_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    term_cfg = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_after_reset();
    run_lists();
  endtask

  task automatic test_field_extremes();
    cfg_write(3'd2);
    load(2'd0, 24'h000000, 16'h0000);
    load(2'd0, 24'hFFFFFF, 16'hFFFF);
    load(2'd1, 24'h000000, 16'hFFFF);
    load(2'd1, 24'hFFFFFF, 16'h0000);
    run_lists();
  endtask

  task automatic test_out_of_order();
    clear_lists();
    load(2'd0, 24'd10, 16'h1234);
    load(2'd0, 24'd5, 16'h5555);
    load(2'd0, 24'd10, 16'h6666);
    load(2'd1, 24'd10, 16'h4321);
    load(2'd1, 24'd20, 16'h7777);
    run_lists();
  endtask

  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 2'd0, 24'd1, 16'hABCD);
    run_lists();
  endtask

  task automatic test_term_count_clamp();
    cfg_write(3'd0);
    run_lists();
    cfg_write(3'd7);
    run_lists();
    load(2'd2, 24'd10, 16'h8001);
    load(2'd3, 24'd10, 16'hC003);
    cfg_write(3'd4);
    run_lists();
  endtask

  task automatic test_no_common();
    clear_lists();
    load(2'd0, 24'd5, 16'h0101);
    load(2'd1, 24'd5, 16'h0202);
    load(2'd2, 24'd7, 16'h0303);
    cfg_write(3'd3);
    // lists 0 and 1 tie on the smallest id, list 0 moves first and runs out
    run_lists();
  endtask

  task automatic test_clear();
    clear_lists();
    run_lists();
  endtask

  // random phases: term count, optional clear, ascending loads with shared ids, run
  task automatic test_random_phases();
    logic [DOC_PORT_W-1:0] d;
    logic [TC_W-1:0] tc;
    logic [3:0] mask;
    int steps;
    int i;
    int t;
    int r;
    bit deep;
    while (items_sent < 480) begin
      r = $urandom_range(0, 9);
      tc = (r < 2) ? ((r == 0) ? 3'd0 : 3'd7) : 3'($urandom_range(0, 7));
      cfg_write(tc);
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) clear_lists();
      deep = ($urandom_range(0, 14) == 0);
      steps = deep ? $urandom_range(60, 70) : $urandom_range(0, 10);
      d = 24'($urandom);
      for (i = 0; i < steps; i++) begin
        d = d + (($urandom_range(0, 9) == 0) ? 24'($urandom_range(1, 1 << 20))
                                             : 24'($urandom_range(1, 4)));
        if (deep) mask = 4'h1 | (($urandom_range(0, 9) < 3) ? 4'hF : 4'h0);
        else mask = ($urandom_range(0, 99) < 35) ? 4'hF : 4'($urandom_range(0, 15));
        for (t = 0; t < TERMS; t++) begin
          if (mask[t]) load(2'(t), d, 16'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 5) send_item(KIND_UNUSED, 2'($urandom), 24'($urandom), 16'($urandom));
        else if (r < 9) load(2'($urandom), d - 24'($urandom_range(0, 3)), 16'($urandom));
        else if (r < 11) run_lists();
      end
      run_lists();
      // a repeated run must restart every head
      if ($urandom_range(0, 9) < 3) run_lists();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_item(2'($urandom_range(0, 3)), 2'($urandom), 24'($urandom), 16'($urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hits_waiting() == 0) begin
        $error("unexpected result: status %0d match_doc %0h last %0b", status, match_doc, last);
        errors++;
      end else begin
        want_hit = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        hits_checked++;
        if (status !== want_hit.status) begin
          $error("status: expected %0d, actual %0d", want_hit.status, status);
          errors++;
        end
        if (match_doc !== want_hit.doc) begin
          $error("match_doc: expected %0h, actual %0h", want_hit.doc, match_doc);
          errors++;
        end
        if (weight_a !== want_hit.wa) begin
          $error("weight_a: expected %0h, actual %0h", want_hit.wa, weight_a);
          errors++;
        end
        if (weight_b !== want_hit.wb) begin
          $error("weight_b: expected %0h, actual %0h", want_hit.wb, weight_b);
          errors++;
        end
        if (weight_c !== want_hit.wc) begin
          $error("weight_c: expected %0h, actual %0h", want_hit.wc, weight_c);
          errors++;
        end
        if (weight_d !== want_hit.wd) begin
          $error("weight_d: expected %0h, actual %0h", want_hit.wd, weight_d);
          errors++;
        end
        if (last !== want_hit.last) begin
          $error("last: expected %0b, actual %0b", want_hit.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("posting_list_intersect verification failed");
    $finish;
  end

  initial begin
    int guard;
    int t;
    errors = 0;
    items_sent = 0;
    items_applied = 0;
    runs_sent = 0;
    hits_checked = 0;
    cfg_writes = 0;
    exp_wr = 0;
    exp_rd = 0;
    no_idle = 1'b0;
    term_cfg = 3'd1;
    for (t = 0; t < TERMS; t++) list_len[t] = 0;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_LOAD;
    term <= '0;
    doc_id <= '0;
    weight <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    test_field_extremes();
    test_out_of_order();
    test_unused_kind();
    test_term_count_clamp();
    test_no_common();
    test_clear();
    test_random_phases();

    start <= 1'b0;
    guard = 0;
    while (hits_waiting() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (hits_waiting() != 0) begin
      $error("results missing at end: %0d still expected", hits_waiting());
      errors++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d items (%0d with effect), %0d runs, %0d results checked",
             items_sent, items_applied, runs_sent, hits_checked);
    $display("term count written %0d times, clamped values and full lists included", cfg_writes);
    if (errors == 0) begin
      $display("posting_list_intersect verification clean");
    end else begin
      $display("posting_list_intersect verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
